>>> src/tof_four_phase_demodulator_top_defines.svh
// Assertion macros shared by the demodulator checker.
// No dependencies; expects clk_i and rst_ni in the scope where they are used.
`ifndef TOF_FOUR_PHASE_DEMODULATOR_TOP_DEFINES_SVH
`define TOF_FOUR_PHASE_DEMODULATOR_TOP_DEFINES_SVH

// Property that must hold at every edge out of reset.
`define TFD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Same-cycle implication.
`define TFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/tfd_pkg.sv
// Shared constants, types and the arctangent table for the ToF demodulator.
// No dependencies.
package tfd_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int STAGES        = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  localparam int FRAC_SHIFT = 16;
  localparam int DIFF_W     = SAMPLE_BITS + 1;
  localparam int XY_W       = SAMPLE_BITS + FRAC_SHIFT + 4;
  localparam int Z_W        = 28;
  localparam int STG_W      = 5;
  localparam int AMP_W      = SAMPLE_BITS + 5;
  localparam int CODE_W     = 8;

  // amplitude = (x * 1/K * 2^24 + 2^35) >> 36
  localparam int INV_W     = 24;
  localparam logic [INV_W-1:0] INV_GAIN = INV_W'(10188014);
  localparam int PROD_W    = XY_W - 1 + INV_W;
  localparam int AMP_SHIFT = 36;
  localparam int RND_W     = PROD_W + 1;
  localparam int AMP_RAW_W = RND_W - AMP_SHIFT;
  localparam logic [RND_W-1:0] AMP_HALF = RND_W'(1) << (AMP_SHIFT - 1);
  localparam logic [AMP_W-1:0] AMP_MAX  = '1;

  // angle in degrees * 2^20
  localparam int DEG_W = 29;
  localparam logic [DEG_W-1:0] DEG_90  = DEG_W'(90)  << 20;
  localparam logic [DEG_W-1:0] DEG_180 = DEG_W'(180) << 20;
  localparam logic [DEG_W-1:0] DEG_360 = DEG_W'(360) << 20;

  // code = (deg*255 + 180*2^20) / (45 * 2^23)
  localparam int NUM_W       = DEG_W + 8;
  localparam int DIV_SHIFT   = 23;
  localparam int QIN_W       = NUM_W - DIV_SHIFT;
  localparam int RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP_45 = RECIP_W'(23302);
  localparam int RECIP_SHIFT = 20;
  localparam int QPROD_W     = QIN_W + RECIP_W;
  localparam int CRAW_W      = QPROD_W - RECIP_SHIFT;
  localparam logic [CODE_W-1:0] CODE_MAX = '1;

  // stream packing
  localparam int IN_RAW_W     = 4 * SAMPLE_BITS;
  localparam int IN_TDATA_W   = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W    = 2 * DIFF_W + AMP_W + CODE_W;
  localparam int OUT_TDATA_W  = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_I_LSB    = 0;
  localparam int OUT_Q_LSB    = DIFF_W;
  localparam int OUT_AMP_LSB  = 2 * DIFF_W;
  localparam int OUT_CODE_LSB = 2 * DIFF_W + AMP_W;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] in_phase;
    logic signed [DIFF_W-1:0] quadrature;
  } tag_t;

  // round(atan(2^-i) deg * 2^20)
  function automatic logic signed [Z_W-1:0] atan_q20(input int idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      0:  v = Z_W'(47185920);
      1:  v = Z_W'(27855475);
      2:  v = Z_W'(14718068);
      3:  v = Z_W'(7471121);
      4:  v = Z_W'(3750058);
      5:  v = Z_W'(1876857);
      6:  v = Z_W'(938658);
      7:  v = Z_W'(469357);
      8:  v = Z_W'(234682);
      9:  v = Z_W'(117342);
      10: v = Z_W'(58671);
      11: v = Z_W'(29335);
      12: v = Z_W'(14668);
      13: v = Z_W'(7334);
      14: v = Z_W'(3667);
      15: v = Z_W'(1833);
      16: v = Z_W'(917);
      17: v = Z_W'(458);
      18: v = Z_W'(229);
      19: v = Z_W'(115);
      20: v = Z_W'(57);
      21: v = Z_W'(29);
      22: v = Z_W'(14);
      23: v = Z_W'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> src/tfd_front.sv
// Input stage: I/Q differences and the folded CORDIC start vector.
// Depends on tfd_pkg.
module tfd_front import tfd_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [SAMPLE_BITS-1:0] s0_i,
  input  logic signed [SAMPLE_BITS-1:0] s180_i,
  input  logic signed [SAMPLE_BITS-1:0] s90_i,
  input  logic signed [SAMPLE_BITS-1:0] s270_i,
  output logic                          valid_o,
  output cordic_t                       vec_o,
  output tag_t                          tag_o
);

  logic signed [DIFF_W-1:0] i_diff, q_diff;
  logic [DIFF_W-1:0]        i_mag, q_mag;
  logic                     valid_q;
  cordic_t                  vec_d, vec_q;
  tag_t                     tag_d, tag_q;

  always_comb begin
    i_diff = DIFF_W'(s0_i) - DIFF_W'(s180_i);
    q_diff = DIFF_W'(s90_i) - DIFF_W'(s270_i);
    i_mag  = i_diff[DIFF_W-1] ? DIFF_W'(-i_diff) : DIFF_W'(i_diff);
    q_mag  = q_diff[DIFF_W-1] ? DIFF_W'(-q_diff) : DIFF_W'(q_diff);
    vec_d.x = {{(XY_W-DIFF_W-FRAC_SHIFT){1'b0}}, q_mag, {FRAC_SHIFT{1'b0}}};
    vec_d.y = {{(XY_W-DIFF_W-FRAC_SHIFT){1'b0}}, i_mag, {FRAC_SHIFT{1'b0}}};
    vec_d.z = '0;
    tag_d.in_phase   = i_diff;
    tag_d.quadrature = q_diff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
      tag_q <= tag_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign tag_o   = tag_q;

endmodule

>>> src/tfd_cordic_cell.sv
// One vectoring CORDIC micro-rotation, registered; I/Q tag rides along.
// Depends on tfd_pkg.
module tfd_cordic_cell import tfd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [STG_W-1:0]      stage_i,
  input  logic signed [Z_W-1:0] atan_i,
  input  logic                  valid_i,
  input  cordic_t               vec_i,
  input  tag_t                  tag_i,
  output logic                  valid_o,
  output cordic_t               vec_o,
  output tag_t                  tag_o
);

  logic signed [XY_W-1:0] xs, ys;
  logic                   valid_q;
  cordic_t                vec_d, vec_q;
  tag_t                   tag_q;

  always_comb begin
    xs = vec_i.x >>> stage_i;
    ys = vec_i.y >>> stage_i;
    if (!vec_i.y[XY_W-1]) begin
      vec_d.x = vec_i.x + ys;
      vec_d.y = vec_i.y - xs;
      vec_d.z = vec_i.z + atan_i;
    end else begin
      vec_d.x = vec_i.x - ys;
      vec_d.y = vec_i.y + xs;
      vec_d.z = vec_i.z - atan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
      tag_q <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign tag_o   = tag_q;

endmodule

>>> src/tfd_post.sv
// Back end: gain correction, quadrant unfold and angle byte, four stages.
// Depends on tfd_pkg. Last stage is the output register.
module tfd_post import tfd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  cordic_t                  vec_i,
  input  tag_t                     tag_i,
  output logic                     valid_o,
  output logic signed [DIFF_W-1:0] in_phase_o,
  output logic signed [DIFF_W-1:0] quadrature_o,
  output logic [AMP_W-1:0]         amplitude_o,
  output logic [CODE_W-1:0]        angle_code_o
);

  logic [3:0] valid_q;

  // stage 1: clamp, multiply by 1/K, unfold angle
  logic              zero_vec, i_neg, q_neg;
  logic [XY_W-2:0]   x_clamp;
  logic [DEG_W-1:0]  z_clamp, deg_d, deg_q;
  logic [PROD_W-1:0] prod_d, prod_q;
  tag_t              tag1_q;

  always_comb begin
    zero_vec = (tag_i.in_phase == '0) && (tag_i.quadrature == '0);
    i_neg    = tag_i.in_phase[DIFF_W-1];
    q_neg    = tag_i.quadrature[DIFF_W-1];
    if (zero_vec || vec_i.x[XY_W-1]) begin
      x_clamp = '0;
    end else begin
      x_clamp = vec_i.x[XY_W-2:0];
    end
    if (vec_i.z[Z_W-1]) begin
      z_clamp = '0;
    end else if (DEG_W'(vec_i.z) > DEG_90) begin
      z_clamp = DEG_90;
    end else begin
      z_clamp = DEG_W'(vec_i.z);
    end
    if (zero_vec) begin
      deg_d = '0;
    end else if (!q_neg && !i_neg) begin
      deg_d = z_clamp;
    end else if (q_neg && !i_neg) begin
      deg_d = DEG_180 - z_clamp;
    end else if (q_neg) begin
      deg_d = DEG_180 + z_clamp;
    end else begin
      deg_d = DEG_360 - z_clamp;
    end
    prod_d = PROD_W'(x_clamp) * PROD_W'(INV_GAIN);
  end

  // stage 2: round and saturate amplitude; scale angle numerator
  logic [RND_W-1:0]     amp_rnd;
  logic [AMP_RAW_W-1:0] amp_raw;
  logic [AMP_W-1:0]     amp_d, amp2_q, amp3_q;
  logic [NUM_W-1:0]     num_d, num_q;
  tag_t                 tag2_q, tag3_q;

  always_comb begin
    amp_rnd = RND_W'(prod_q) + AMP_HALF;
    amp_raw = amp_rnd[RND_W-1:AMP_SHIFT];
    amp_d   = (amp_raw > AMP_RAW_W'(AMP_MAX)) ? AMP_MAX : amp_raw[AMP_W-1:0];
    num_d   = NUM_W'(deg_q) * NUM_W'(255) + NUM_W'(DEG_180);
  end

  // stage 3: divide by 45 through the reciprocal
  logic [QPROD_W-1:0] qprod_d, qprod_q;
  logic [CRAW_W-1:0]  code_raw;
  logic [CODE_W-1:0]  code_d;

  always_comb begin
    qprod_d  = QPROD_W'(num_q[NUM_W-1:DIV_SHIFT]) * QPROD_W'(RECIP_45);
    code_raw = qprod_q[QPROD_W-1:RECIP_SHIFT];
    code_d   = (code_raw > CRAW_W'(CODE_MAX)) ? CODE_MAX : code_raw[CODE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q       <= prod_d;
      deg_q        <= deg_d;
      tag1_q       <= tag_i;
      amp2_q       <= amp_d;
      num_q        <= num_d;
      tag2_q       <= tag1_q;
      amp3_q       <= amp2_q;
      qprod_q      <= qprod_d;
      tag3_q       <= tag2_q;
      in_phase_o   <= tag3_q.in_phase;
      quadrature_o <= tag3_q.quadrature;
      amplitude_o  <= amp3_q;
      angle_code_o <= code_d;
    end
  end

  assign valid_o = valid_q[3];

endmodule

>>> src/tof_four_phase_demodulator_top.sv
// Four-phase ToF demodulator: I/Q, CORDIC magnitude and angle byte per pixel.
// Pipeline registers: 1 input, 1 per cell, 4 back end.
// Throughput: one beat per cycle while the output is not stalled; every stage is a register of a single pipeline.
// Backpressure: a held output beat freezes the whole pipeline, nothing is dropped.
// Reset (rst_ni, async, active low) clears the valid bits only; data regs are not reset.
// Depends on tfd_pkg, tfd_front, tfd_cordic_cell, tfd_post.
module tof_four_phase_demodulator_top import tfd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // slave side
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata, LSB up: sample_0deg, sample_180deg, sample_90deg, sample_270deg
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // master side
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata, LSB up: in_phase, quadrature, amplitude, angle_code, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Global advance: move when the output register is empty or being taken.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Chain links: index 0 is the front-end output, STAGES the last cell.
  logic    valid_c [0:STAGES];
  cordic_t vec_c   [0:STAGES];
  tag_t    tag_c   [0:STAGES];

  tfd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .s0_i    (s_axis_tdata[0*SAMPLE_BITS +: SAMPLE_BITS]),
    .s180_i  (s_axis_tdata[1*SAMPLE_BITS +: SAMPLE_BITS]),
    .s90_i   (s_axis_tdata[2*SAMPLE_BITS +: SAMPLE_BITS]),
    .s270_i  (s_axis_tdata[3*SAMPLE_BITS +: SAMPLE_BITS]),
    .valid_o (valid_c[0]),
    .vec_o   (vec_c[0]),
    .tag_o   (tag_c[0])
  );

  // Row of micro-rotation cells; each cell gets its fixed shift and table entry.
  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    tfd_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (STG_W'(g)),
      .atan_i  (atan_q20(g)),
      .valid_i (valid_c[g]),
      .vec_i   (vec_c[g]),
      .tag_i   (tag_c[g]),
      .valid_o (valid_c[g+1]),
      .vec_o   (vec_c[g+1]),
      .tag_o   (tag_c[g+1])
    );
  end

  logic signed [DIFF_W-1:0] in_phase, quadrature;
  logic [AMP_W-1:0]         amplitude;
  logic [CODE_W-1:0]        angle_code;

  // Gain correction and angle mapping; its last stage is the output register.
  tfd_post u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (valid_c[STAGES]),
    .vec_i        (vec_c[STAGES]),
    .tag_i        (tag_c[STAGES]),
    .valid_o      (m_axis_tvalid),
    .in_phase_o   (in_phase),
    .quadrature_o (quadrature),
    .amplitude_o  (amplitude),
    .angle_code_o (angle_code)
  );

  assign m_axis_tdata = OUT_TDATA_W'({angle_code, amplitude, quadrature, in_phase});

endmodule

>>> src/tfd_checker.sv
// Port-level checker for the demodulator top, bound in below.
// Depends on tfd_pkg and tof_four_phase_demodulator_top_defines.svh.
`include "tof_four_phase_demodulator_top_defines.svh"

module tfd_checker import tfd_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic zero_iq, out_stall, amp_code_zero;
  assign zero_iq = (m_axis_tdata[OUT_I_LSB +: DIFF_W] == '0) &&
                   (m_axis_tdata[OUT_Q_LSB +: DIFF_W] == '0);
  assign out_stall     = m_axis_tvalid && !m_axis_tready;
  assign amp_code_zero = (m_axis_tdata[OUT_TDATA_W-1:OUT_AMP_LSB] == '0);

  // stalled beat stays up and holds its data
  `TFD_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "out beat dropped")
  `TFD_ASSERT_NEXT(a_out_stable, out_stall, $stable(m_axis_tdata), "out data moved")
  // an empty output register never blocks the input
  `TFD_ASSERT_IMPL(a_ready_free, !m_axis_tvalid, s_axis_tready, "input blocked")
  // zero vector gives zero amplitude and angle
  `TFD_ASSERT_IMPL(a_zero_vec, m_axis_tvalid && zero_iq, amp_code_zero, "zero vector not zero")

endmodule

bind tof_four_phase_demodulator_top tfd_checker u_tfd_checker (.*);

>>> tb/sv/tof_four_phase_demodulator_top_tb.sv
// Self-checking testbench for the four-phase ToF demodulator: directed pixels, then random
// pixel streams under three idle patterns; beats checked against typed results or a CORDIC model.
// Depends on tfd_pkg and tof_four_phase_demodulator_top.
module tof_four_phase_demodulator_top_tb;
  import tfd_pkg::*;

  localparam int  PIXELS_PER_PHASE = 234;
  localparam int  SETTLE_CYCLES    = 40;       // pipeline is 21 deep
  localparam int  LIMIT_CYCLES     = 200000;
  localparam int  FRAC_BITS        = 16;
  localparam longint GAIN_Q24      = 10188014; // 1/K * 2^24
  localparam longint DEG_UNIT      = 1 << 20;
  localparam longint AMP_LIMIT     = (1 << AMP_W) - 1;
  localparam longint CODE_LIMIT    = 255;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_0deg;
    logic signed [SAMPLE_BITS-1:0] sample_180deg;
    logic signed [SAMPLE_BITS-1:0] sample_90deg;
    logic signed [SAMPLE_BITS-1:0] sample_270deg;
  } pixel_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] in_phase;
    logic signed [DIFF_W-1:0] quadrature;
    logic        [AMP_W-1:0]  amplitude;
    logic        [CODE_W-1:0] angle_code;
  } demod_beat_t;

  typedef struct packed {
    pixel_t      px;
    bit          typed;   // expected beat written out below, not computed
    demod_beat_t want;
  } pixel_row_t;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  demod_beat_t pending_beats [$];
  int          mismatch_count = 0;
  int          sender_idle_pct   = 28;
  int          receiver_idle_pct = 59;

  // round(atan(2^-i) in degrees * 2^20)
  longint atan_steps [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  // Zero-vector rows carry their result; the rest go through the model.
  pixel_row_t directed_rows [20] = '{
    '{'{0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0}},
    '{'{2047, 2047, 2047, 2047}, 1'b1, '{0, 0, 0, 0}},
    '{'{-2048, -2048, -2048, -2048}, 1'b1, '{0, 0, 0, 0}},
    '{'{-1, -1, 5, 5}, 1'b1, '{0, 0, 0, 0}},
    '{'{-2048, -2048, -1, -1}, 1'b1, '{0, 0, 0, 0}},
    '{'{2047, -2048, 0, 0}, 1'b0, '0},         // +I axis, 90 deg
    '{'{-2048, 2047, 0, 0}, 1'b0, '0},         // -I axis, 270 deg
    '{'{0, 0, 2047, -2048}, 1'b0, '0},         // +Q axis, 0 deg
    '{'{0, 0, -2048, 2047}, 1'b0, '0},         // -Q axis, 180 deg
    '{'{2047, -2048, 2047, -2048}, 1'b0, '0},  // largest magnitude, first quadrant
    '{'{2047, -2048, -2048, 2047}, 1'b0, '0},  // I>0, Q<0
    '{'{-2048, 2047, -2048, 2047}, 1'b0, '0},  // I<0, Q<0
    '{'{-2048, 2047, 2047, -2048}, 1'b0, '0},  // I<0, Q>0
    '{'{-1, 0, 2047, -2048}, 1'b0, '0},        // just below 360 deg
    '{'{1, 0, -2048, 2047}, 1'b0, '0},         // just below 180 deg
    '{'{1, 0, 0, 0}, 1'b0, '0},                // smallest nonzero I
    '{'{0, 0, 1, 0}, 1'b0, '0},                // smallest nonzero Q
    '{'{0, 1, 0, 1}, 1'b0, '0},
    '{'{100, -100, 173, 0}, 1'b0, '0},
    '{'{1365, -1366, -1366, 1365}, 1'b0, '0}   // alternating bit patterns
  };

  tof_four_phase_demodulator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("tof_four_phase_demodulator_top_tb NOT OK");
    $finish;
  end

  // I/Q differences, vectoring CORDIC on |Q|,|I|, then quadrant fold and angle byte.
  function automatic demod_beat_t demodulate(pixel_t px);
    demod_beat_t r;
    longint i_v, q_v, x, y, z, xs, ys, deg, mag, code;
    i_v = longint'(px.sample_0deg) - longint'(px.sample_180deg);
    q_v = longint'(px.sample_90deg) - longint'(px.sample_270deg);
    r.in_phase   = DIFF_W'(i_v);
    r.quadrature = DIFF_W'(q_v);
    r.amplitude  = '0;
    r.angle_code = '0;
    if (i_v != 0 || q_v != 0) begin
      x = (q_v < 0 ? -q_v : q_v) <<< FRAC_BITS;
      y = (i_v < 0 ? -i_v : i_v) <<< FRAC_BITS;
      z = 0;
      for (int k = 0; k < STAGES; k++) begin
        xs = x >>> k;
        ys = y >>> k;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_steps[k];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_steps[k];
        end
      end
      if (x < 0) x = 0;
      mag = (x * GAIN_Q24 + (longint'(1) <<< 35)) >>> 36;
      if (mag > AMP_LIMIT) mag = AMP_LIMIT;
      if (z < 0) z = 0;
      if (z > 90 * DEG_UNIT) z = 90 * DEG_UNIT;
      if (q_v >= 0 && i_v >= 0) deg = z;
      else if (q_v < 0 && i_v >= 0) deg = 180 * DEG_UNIT - z;
      else if (q_v < 0) deg = 180 * DEG_UNIT + z;
      else deg = 360 * DEG_UNIT - z;
      code = (deg * 255 + 180 * DEG_UNIT) / (360 * DEG_UNIT);
      if (code > CODE_LIMIT) code = CODE_LIMIT;
      r.amplitude  = AMP_W'(mag);
      r.angle_code = CODE_W'(code);
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] extreme_sample();
    case ($urandom_range(3))
      0: return SAMPLE_BITS'(-2048);
      1: return SAMPLE_BITS'(2047);
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // Uniform samples, with over half of them steered onto the axes, the origin,
  // the corners and tiny vectors.
  function automatic pixel_t random_pixel();
    pixel_t px;
    int     pick;
    px.sample_0deg   = SAMPLE_BITS'($urandom);
    px.sample_180deg = SAMPLE_BITS'($urandom);
    px.sample_90deg  = SAMPLE_BITS'($urandom);
    px.sample_270deg = SAMPLE_BITS'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) begin
      px.sample_180deg = px.sample_0deg;
    end else if (pick < 20) begin
      px.sample_270deg = px.sample_90deg;
    end else if (pick < 25) begin
      px.sample_180deg = px.sample_0deg;
      px.sample_270deg = px.sample_90deg;
    end else if (pick < 40) begin
      px.sample_0deg   = extreme_sample();
      px.sample_180deg = extreme_sample();
      px.sample_90deg  = extreme_sample();
      px.sample_270deg = extreme_sample();
    end else if (pick < 55) begin
      px.sample_180deg = px.sample_0deg + SAMPLE_BITS'($urandom_range(6)) - SAMPLE_BITS'(3);
      px.sample_270deg = px.sample_90deg + SAMPLE_BITS'($urandom_range(6)) - SAMPLE_BITS'(3);
    end
    return px;
  endfunction

  // Entered at the edge where the previous beat went in; leaves at the edge
  // where this one is taken, with its expected result queued.
  task automatic send_pixel(pixel_t px, bit typed, demod_beat_t want);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({px.sample_270deg, px.sample_90deg,
                                  px.sample_180deg, px.sample_0deg});
    do @(posedge clk_i); while (!s_axis_tready);
    pending_beats.push_back(typed ? want : demodulate(px));
  endtask

  // Hold the input off until the pipeline has emptied.
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_beats.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  always @(posedge clk_i) begin
    demod_beat_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.in_phase   = m_axis_tdata[OUT_I_LSB +: DIFF_W];
      got.quadrature = m_axis_tdata[OUT_Q_LSB +: DIFF_W];
      got.amplitude  = m_axis_tdata[OUT_AMP_LSB +: AMP_W];
      got.angle_code = m_axis_tdata[OUT_CODE_LSB +: CODE_W];
      if (pending_beats.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected output beat: I=%0d Q=%0d amp=%0d code=%0d",
                   got.in_phase, got.quadrature, got.amplitude, got.angle_code);
        mismatch_count++;
      end else begin
        want = pending_beats.pop_front();
        if (got.in_phase !== want.in_phase || got.quadrature !== want.quadrature ||
            got.amplitude !== want.amplitude || got.angle_code !== want.angle_code) begin
          if (mismatch_count < 10)
            $display("mismatch: exp I=%0d Q=%0d amp=%0d code=%0d, got I=%0d Q=%0d amp=%0d code=%0d",
                     want.in_phase, want.quadrature, want.amplitude, want.angle_code,
                     got.in_phase, got.quadrature, got.amplitude, got.angle_code);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_rows[n])
      send_pixel(directed_rows[n].px, directed_rows[n].typed, directed_rows[n].want);
    drain_pipeline();

    // receiver-heavy stalls, then sender-heavy gaps, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct   = (phase == 0) ? 28 : (phase == 1) ? 59 : 0;
      receiver_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 28 : 0;
      repeat (PIXELS_PER_PHASE) send_pixel(random_pixel(), 1'b0, '0);
      if (phase < 2) drain_pipeline();
    end

    s_axis_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0)
      $display("tof_four_phase_demodulator_top_tb OK");
    else
      $display("tof_four_phase_demodulator_top_tb NOT OK");
    $finish;
  end

endmodule
